/* src/md5_message_digest_unit_assert.svh */
// assertion macros used by the md5 back end
// each expects clk and rst_n in the scope where it is used
`ifndef MD5_MESSAGE_DIGEST_UNIT_ASSERT_SVH
`define MD5_MESSAGE_DIGEST_UNIT_ASSERT_SVH

// condition in this cycle implies a condition in the same cycle
`define MD5_ASSERT_IMPLIES(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("md5 check failed: same-cycle implication");

// condition in this cycle implies a condition in the next cycle
`define MD5_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("md5 check failed: next-cycle implication");

`endif

/* src/md5_pkg.sv */
package md5_pkg;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // block geometry
    localparam int BLOCK_BYTES = 64;
    localparam int BLOCK_WORDS = BLOCK_BYTES / 4;
    localparam int ROUNDS      = 64;
    localparam int COUNT_W     = 61;

    // chaining word initial values
    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;

    // padding
    localparam logic [7:0] PAD_MARKER = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;
    localparam logic [3:0] LEN_LO_WORD = 4'd14;
    localparam logic [3:0] LEN_HI_WORD = 4'd15;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } out_item_t;

    // classified request handed from front to back
    typedef struct packed {
        logic       has_byte;
        logic       ends;
        logic [7:0] data;
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } state_t;

    // additive constant of each round
    function automatic logic [31:0] step_const(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0:  k = 32'hd76aa478;
            6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;
            6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;
            6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;
            6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;
            6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;
            6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;
            6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;
            6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;
            6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;
            6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;
            6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;
            6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;
            6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;
            6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;
            6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;
            6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;
            6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;
            6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;
            6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;
            6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;
            6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;
            6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;
            6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;
            6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;
            6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;
            6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;
            6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;
            6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;
            6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;
            6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;
            6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;
            6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    // left rotate amount of each round
    function automatic logic [4:0] rot_amt(input logic [5:0] r);
        logic [4:0] s;
        case ({r[5:4], r[1:0]})
            4'h0: s = 5'd7;
            4'h1: s = 5'd12;
            4'h2: s = 5'd17;
            4'h3: s = 5'd22;
            4'h4: s = 5'd5;
            4'h5: s = 5'd9;
            4'h6: s = 5'd14;
            4'h7: s = 5'd20;
            4'h8: s = 5'd4;
            4'h9: s = 5'd11;
            4'ha: s = 5'd16;
            4'hb: s = 5'd23;
            4'hc: s = 5'd6;
            4'hd: s = 5'd10;
            4'he: s = 5'd15;
            4'hf: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // message word used by each round
    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] i4;
        logic [3:0] g;
        i4 = r[3:0];
        case (r[5:4])
            2'd0:    g = i4;
            2'd1:    g = (i4 << 2) + i4 + 4'd1;
            2'd2:    g = (i4 << 1) + i4 + 4'd5;
            2'd3:    g = (i4 << 3) - i4;
            default: g = i4;
        endcase
        return g;
    endfunction

    // boolean function of each quarter
    function automatic logic [31:0] round_fn(input logic [1:0] q, input logic [31:0] b,
                                             input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        case (q)
            2'd0:    f = (b & c) | (~b & d);
            2'd1:    f = (b & d) | (c & ~d);
            2'd2:    f = b ^ c ^ d;
            2'd3:    f = c ^ (b | ~d);
            default: f = b ^ c ^ d;
        endcase
        return f;
    endfunction

endpackage

/* src/md5_chan_if.sv */
interface md5_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/md5_front.sv */
module md5_front (
    input  logic              clk,
    input  logic              rst_n,
    md5_chan_if.sink          in_ch,
    output logic              op_valid,
    output md5_pkg::op_t      op,
    input  logic              op_ready
);

    logic         op_valid_reg;
    logic         op_valid_next;
    md5_pkg::op_t op_reg;
    logic         take;
    logic         keep;

    // stage is free when empty or draining this cycle
    assign in_ch.ready = !op_valid_reg || op_ready;
    assign take        = in_ch.valid && in_ch.ready;
    // requests with neither flag carry no work and are dropped here
    assign keep        = in_ch.data.byte_valid || in_ch.data.end_of_message;

    // valid tracking
    always_comb
    begin
        op_valid_next = op_valid_reg;
        if (op_ready)
        begin
            op_valid_next = 1'b0;
        end
        if (take && keep)
        begin
            op_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg <= 1'b0;
        end
        else
        begin
            op_valid_reg <= op_valid_next;
        end
    end

    // classified payload
    always_ff @(posedge clk)
    begin
        if (take && keep)
        begin
            op_reg.has_byte <= in_ch.data.byte_valid;
            op_reg.ends     <= in_ch.data.end_of_message;
            op_reg.data     <= in_ch.data.data_byte;
        end
    end

    assign op_valid = op_valid_reg;
    assign op       = op_reg;

endmodule

/* src/md5_queue.sv */
module md5_queue #(
    parameter int DEPTH = md5_pkg::QUEUE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    input  md5_pkg::op_t push_op,
    output logic         push_ready,
    output logic         pop_valid,
    output md5_pkg::op_t pop_op,
    input  logic         pop_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    md5_pkg::op_t     slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_op     = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

/* src/md5_back.sv */
`include "md5_message_digest_unit_assert.svh"

module md5_back (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         op_valid,
    input  md5_pkg::op_t op,
    output logic         op_pop,
    md5_chan_if.source   out_ch
);

    localparam logic [5:0] LAST_ROUND = 6'(md5_pkg::ROUNDS - 1);
    localparam logic [6:0] FULL_LIM   = 7'(md5_pkg::BLOCK_BYTES);
    localparam logic [5:0] LAST_POS   = 6'(md5_pkg::BLOCK_BYTES - 1);

    md5_pkg::state_t  state_reg;
    md5_pkg::state_t  state_next;
    logic [5:0]       round_reg;
    logic [5:0]       round_next;
    logic [31:0]      a_reg, b_reg, c_reg, d_reg;
    logic [31:0]      a_next, b_next, c_next, d_next;
    logic [31:0]      chain_reg [4];
    logic [31:0]      chain_next [4];
    logic [md5_pkg::COUNT_W-1:0] cnt_reg;
    logic [md5_pkg::COUNT_W-1:0] cnt_next;
    logic             end_pend_reg, end_pend_next;
    logic [6:0]       lim_reg, lim_next;
    logic             mark_reg, mark_next;
    logic             len_reg, len_next;
    logic [1:0]       emit_idx_reg, emit_idx_next;
    logic             out_valid_reg, out_valid_next;
    md5_pkg::out_item_t out_item_reg;

    // block buffer, sixteen little-endian words
    logic [31:0]      buf_mem [md5_pkg::BLOCK_WORDS];
    logic [31:0]      rd_data_reg;
    logic [3:0]       rd_g_reg;
    logic             mem_we;
    logic [3:0]       mem_waddr;
    logic [1:0]       mem_wlane;
    logic [3:0]       mem_raddr;
    logic             emit_load;

    // round datapath signals
    logic [31:0]      w_word;
    logic [31:0]      sum;
    logic [63:0]      rot_dbl;
    logic [31:0]      rot_out;
    logic [5:0]       pad_pos;
    logic             full_block;

    // message word with padding and length folded in
    always_comb
    begin
        logic [6:0] idx;
        w_word = '0;
        for (int lane = 0; lane < 4; lane++)
        begin
            idx = {1'b0, rd_g_reg, 2'(lane)};
            if (idx < lim_reg)
            begin
                w_word[8*lane +: 8] = rd_data_reg[8*lane +: 8];
            end
            else if (mark_reg && (idx == lim_reg))
            begin
                w_word[8*lane +: 8] = md5_pkg::PAD_MARKER;
            end
        end
        if (len_reg && (rd_g_reg == md5_pkg::LEN_LO_WORD))
        begin
            w_word = {cnt_reg[28:0], 3'b000};
        end
        else if (len_reg && (rd_g_reg == md5_pkg::LEN_HI_WORD))
        begin
            w_word = cnt_reg[60:29];
        end
    end

    // one md5 step
    assign sum     = a_reg + md5_pkg::round_fn(round_reg[5:4], b_reg, c_reg, d_reg)
                   + md5_pkg::step_const(round_reg) + w_word;
    assign rot_dbl = {sum, sum} << md5_pkg::rot_amt(round_reg);
    assign rot_out = rot_dbl[63:32];

    // padding position and block-full test for the request at the head
    assign full_block = op.has_byte && (cnt_reg[5:0] == LAST_POS);
    assign pad_pos    = op.has_byte ? cnt_reg[5:0] + 6'd1 : cnt_reg[5:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            md5_pkg::ST_IDLE:
            begin
                if (op_valid && (full_block || op.ends))
                begin
                    state_next = md5_pkg::ST_LOAD;
                end
            end
            md5_pkg::ST_LOAD:
            begin
                state_next = md5_pkg::ST_ROUND;
            end
            md5_pkg::ST_ROUND:
            begin
                if (round_reg == LAST_ROUND)
                begin
                    state_next = md5_pkg::ST_FOLD;
                end
            end
            md5_pkg::ST_FOLD:
            begin
                if (len_reg)
                begin
                    state_next = md5_pkg::ST_EMIT;
                end
                else if (mark_reg || end_pend_reg)
                begin
                    state_next = md5_pkg::ST_LOAD;
                end
                else
                begin
                    state_next = md5_pkg::ST_IDLE;
                end
            end
            md5_pkg::ST_EMIT:
            begin
                if (emit_load && (emit_idx_reg == 2'd3))
                begin
                    state_next = md5_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = md5_pkg::ST_IDLE;
            end
        endcase
    end

    // control outputs of the sequencer
    always_comb
    begin
        op_pop    = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = cnt_reg[5:2];
        mem_wlane = cnt_reg[1:0];
        mem_raddr = md5_pkg::msg_index(round_reg + 6'd1);
        emit_load = 1'b0;
        case (state_reg)
            md5_pkg::ST_IDLE:
            begin
                op_pop = op_valid;
                mem_we = op_valid && op.has_byte;
            end
            md5_pkg::ST_LOAD:
            begin
                mem_raddr = md5_pkg::msg_index(6'd0);
            end
            md5_pkg::ST_EMIT:
            begin
                emit_load = !out_valid_reg || out_ch.ready;
            end
            default:
            begin
                op_pop = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        round_next     = round_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        chain_next     = chain_reg;
        cnt_next       = cnt_reg;
        end_pend_next  = end_pend_reg;
        lim_next       = lim_reg;
        mark_next      = mark_reg;
        len_next       = len_reg;
        emit_idx_next  = emit_idx_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        case (state_reg)
            md5_pkg::ST_IDLE:
            begin
                if (op_valid)
                begin
                    if (op.has_byte)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    end_pend_next = op.ends;
                    if (full_block)
                    begin
                        lim_next  = FULL_LIM;
                        mark_next = 1'b0;
                        len_next  = 1'b0;
                    end
                    else if (op.ends)
                    begin
                        lim_next  = {1'b0, pad_pos};
                        mark_next = 1'b1;
                        len_next  = (pad_pos < md5_pkg::LEN_OFFSET);
                    end
                end
            end
            md5_pkg::ST_LOAD:
            begin
                round_next = '0;
                a_next     = chain_reg[0];
                b_next     = chain_reg[1];
                c_next     = chain_reg[2];
                d_next     = chain_reg[3];
            end
            md5_pkg::ST_ROUND:
            begin
                round_next = round_reg + 6'd1;
                a_next     = d_reg;
                d_next     = c_reg;
                c_next     = b_reg;
                b_next     = b_reg + rot_out;
            end
            md5_pkg::ST_FOLD:
            begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
                if (len_reg)
                begin
                    emit_idx_next = '0;
                end
                else if (mark_reg)
                begin
                    // marker block done, length goes in a block of its own
                    lim_next  = '0;
                    mark_next = 1'b0;
                    len_next  = 1'b1;
                end
                else if (end_pend_reg)
                begin
                    // full block ended the message, pad from its start
                    lim_next  = '0;
                    mark_next = 1'b1;
                    len_next  = 1'b1;
                end
            end
            md5_pkg::ST_EMIT:
            begin
                if (emit_load)
                begin
                    out_valid_next = 1'b1;
                    emit_idx_next  = emit_idx_reg + 2'd1;
                    if (emit_idx_reg == 2'd3)
                    begin
                        chain_next[0] = md5_pkg::INIT_A;
                        chain_next[1] = md5_pkg::INIT_B;
                        chain_next[2] = md5_pkg::INIT_C;
                        chain_next[3] = md5_pkg::INIT_D;
                        cnt_next      = '0;
                        end_pend_next = 1'b0;
                        len_next      = 1'b0;
                        mark_next     = 1'b0;
                    end
                end
            end
            default:
            begin
                round_next = round_reg;
            end
        endcase
    end

    // control and chaining registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= md5_pkg::ST_IDLE;
            round_reg     <= '0;
            chain_reg[0]  <= md5_pkg::INIT_A;
            chain_reg[1]  <= md5_pkg::INIT_B;
            chain_reg[2]  <= md5_pkg::INIT_C;
            chain_reg[3]  <= md5_pkg::INIT_D;
            cnt_reg       <= '0;
            end_pend_reg  <= 1'b0;
            lim_reg       <= FULL_LIM;
            mark_reg      <= 1'b0;
            len_reg       <= 1'b0;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            chain_reg     <= chain_next;
            cnt_reg       <= cnt_next;
            end_pend_reg  <= end_pend_next;
            lim_reg       <= lim_next;
            mark_reg      <= mark_next;
            len_reg       <= len_next;
            emit_idx_reg  <= emit_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working variables
    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
    end

    // block buffer write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            buf_mem[mem_waddr][8*mem_wlane +: 8] <= op.data;
        end
        rd_data_reg <= buf_mem[mem_raddr];
        rd_g_reg    <= mem_raddr;
    end

    // digest output register
    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            out_item_reg.digest_word <= chain_reg[emit_idx_reg];
            out_item_reg.word_index  <= emit_idx_reg;
            out_item_reg.last_word   <= (emit_idx_reg == 2'd3);
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_item_reg;

    `MD5_ASSERT_NEXT(a_load_starts_round, state_reg == md5_pkg::ST_LOAD, (state_reg == md5_pkg::ST_ROUND) && (round_reg == 6'd0))
    `MD5_ASSERT_NEXT(a_last_round_folds, (state_reg == md5_pkg::ST_ROUND) && (round_reg == LAST_ROUND), state_reg == md5_pkg::ST_FOLD)
    `MD5_ASSERT_IMPLIES(a_pop_only_idle, op_pop, state_reg == md5_pkg::ST_IDLE)
    `MD5_ASSERT_IMPLIES(a_marker_fits_length, (state_reg == md5_pkg::ST_ROUND) && len_reg && mark_reg, lim_reg < 7'd56)

endmodule

/* src/md5_message_digest_unit.sv */
// channel   dir  payload
// in_ch     in   data_byte, byte_valid, end_of_message
// out_ch    out  digest_word, word_index, last_word
//
// a byte request is taken by the back end while it is idle; a request with no flag set is dropped in the front end
// each full 64-byte block goes through word fetch, 64 rounds on one round unit, then fold
// an end request adds one or two padded blocks (two when 56 or more bytes sit in the
// block), then the four digest words are sent, held while the output stalls
// reset clears the chaining words to their initial values and the byte count to zero
// the queue lets the front keep taking requests while the back compresses or the
// output stalls
module md5_message_digest_unit #(
    parameter int QUEUE_DEPTH = md5_pkg::QUEUE_DEPTH
) (
    input logic        clk,
    input logic        rst_n,
    md5_chan_if.sink   in_ch,
    md5_chan_if.source out_ch
);

    logic         f_valid;
    md5_pkg::op_t f_op;
    logic         f_ready;
    logic         q_valid;
    md5_pkg::op_t q_op;
    logic         q_pop;

    // request intake and classification
    md5_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .op_valid (f_valid),
        .op       (f_op),
        .op_ready (f_ready)
    );

    // decoupling queue
    md5_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_op    (f_op),
        .push_ready (f_ready),
        .pop_valid  (q_valid),
        .pop_op     (q_op),
        .pop_ready  (q_pop)
    );

    // block buffer, rounds and digest output
    md5_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (q_valid),
        .op       (q_op),
        .op_pop   (q_pop),
        .out_ch   (out_ch)
    );

endmodule
